>>> hdl/multi_motor_encoder_unwrap_unit_macros.svh
// Assertion helpers shared by the encoder unwrap RTL.
// Every check is clocked on clk_i and switched off while rst_ni is low.
`ifndef MULTI_MOTOR_ENCODER_UNWRAP_UNIT_MACROS_SVH
`define MULTI_MOTOR_ENCODER_UNWRAP_UNIT_MACROS_SVH

// Same-cycle implication.
`define MMEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MMEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mmeu_pkg.sv
package mmeu_pkg;

  // Fixed field widths of the feedback frame and of the result beat.
  localparam int unsigned NumberW   = 4;
  localparam int unsigned AngleRawW = 13;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned SlotOutW  = 3;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned StepW     = 14;

  // Widest encoder angle the unit supports.
  localparam int unsigned AngleMaxW = 16;

endpackage

>>> hdl/mmeu_step_calc.sv
module mmeu_step_calc #(
  parameter int unsigned ANGLE_BITS = 13
) (
  input  logic [ANGLE_BITS-1:0] old_angle_i,
  input  logic [ANGLE_BITS-1:0] new_angle_i,
  output logic signed [ANGLE_BITS:0] step_o
);

  logic [ANGLE_BITS-1:0] diff;
  logic                  is_half;

  // Difference modulo one revolution; as a signed value it is already the
  // shortest step, except at exactly half a turn.
  assign diff    = new_angle_i - old_angle_i;
  assign is_half = (diff == {1'b1, {(ANGLE_BITS-1){1'b0}}});

  // A half-turn tie goes positive only when the new angle is above the old.
  always_comb begin
    if (is_half && (new_angle_i > old_angle_i)) begin
      step_o = {1'b0, diff};
    end else begin
      step_o = {diff[ANGLE_BITS-1], diff};
    end
  end

endmodule

>>> hdl/mmeu_motor_state.sv
module mmeu_motor_state #(
  parameter int unsigned MOTOR_COUNT = 8,
  parameter int unsigned ANGLE_BITS  = 13,
  localparam int unsigned SlotW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [SlotW-1:0]          slot_i,
  input  logic [ANGLE_BITS-1:0]     angle_i,
  input  logic [mmeu_pkg::TotalW-1:0] total_i,
  output logic [ANGLE_BITS-1:0]     prev_angle_o,
  output logic [mmeu_pkg::TotalW-1:0] prev_total_o
);

  logic [ANGLE_BITS-1:0]         angle_q [MOTOR_COUNT];
  logic [mmeu_pkg::TotalW-1:0]   total_q [MOTOR_COUNT];

  // Per-motor last angle and running total, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        angle_q[i] <= '0;
        total_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      angle_q[slot_i] <= angle_i;
      total_q[slot_i] <= total_i;
    end
  end

  // Read port for the motor in the input stage.
  assign prev_angle_o = angle_q[slot_i];
  assign prev_total_o = total_q[slot_i];

endmodule

>>> hdl/multi_motor_encoder_unwrap_unit.sv
// Beats pass through the input stage registers, then the result register at the ports.
// Throughput: one frame per cycle while out_ready_i does not hold a result back; the
// per-motor state is read, unwrapped and written back in the same cycle, so consecutive frames for one motor chain.
// Reset: rst_ni clears all valid flags and every motor's stored angle and total.
// Result beats wait in the output register; the input stage takes one more beat behind it, then stalls.
`include "multi_motor_encoder_unwrap_unit_macros.svh"

module multi_motor_encoder_unwrap_unit #(
  parameter int unsigned MOTOR_COUNT = 8,
  parameter int unsigned ANGLE_BITS  = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mmeu_pkg::NumberW-1:0]        motor_number_i,
  input  logic [mmeu_pkg::AngleRawW-1:0]      angle_raw_i,
  input  logic signed [mmeu_pkg::SpeedW-1:0]  speed_raw_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mmeu_pkg::SlotOutW-1:0]       motor_slot_o,
  output logic                                number_valid_o,
  output logic signed [mmeu_pkg::TotalW-1:0]  angle_total_o,
  output logic signed [mmeu_pkg::StepW-1:0]   angle_step_o,
  output logic signed [mmeu_pkg::SpeedW-1:0]  speed_out_o
);

  localparam int unsigned SlotW  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int unsigned NumW   = mmeu_pkg::NumberW;
  localparam int unsigned TotW   = mmeu_pkg::TotalW;
  localparam logic [NumW-1:0] MotorLast = MOTOR_COUNT[NumW-1:0];

  // Input stage registers.
  logic                      in_valid_q;
  logic [NumW-1:0]           number_q;
  logic [ANGLE_BITS-1:0]     angle_q;
  logic [mmeu_pkg::SpeedW-1:0] speed_q;

  // Result registers.
  logic                      out_valid_q;
  logic [mmeu_pkg::SlotOutW-1:0] slot_q, slot_d;
  logic                      num_ok_q, num_ok_d;
  logic [TotW-1:0]           total_q, total_d;
  logic [mmeu_pkg::StepW-1:0] step_q, step_d;
  logic [mmeu_pkg::SpeedW-1:0] speed_out_q;

  logic                      advance;
  logic                      fire;
  logic [NumW-1:0]           number_m1;
  logic [mmeu_pkg::AngleMaxW-1:0] angle_ext;
  logic [ANGLE_BITS-1:0]     prev_angle;
  logic [TotW-1:0]           prev_total;
  logic [TotW-1:0]           new_total;
  logic signed [ANGLE_BITS:0] step;
  logic [TotW-1:0]           step_ext;

  // Handshake: the input stage moves on whenever the result register frees up.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  // Fit the raw angle to the configured encoder width.
  assign angle_ext = {{(mmeu_pkg::AngleMaxW - mmeu_pkg::AngleRawW){1'b0}}, angle_raw_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      number_q <= motor_number_i;
      angle_q  <= angle_ext[ANGLE_BITS-1:0];
      speed_q  <= speed_raw_i;
    end
  end

  // Motor number decode.
  assign num_ok_d  = (number_q != '0) && (number_q <= MotorLast);
  assign number_m1 = number_q - NumW'(1);

  mmeu_motor_state #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (fire && num_ok_d),
    .slot_i       (number_m1[SlotW-1:0]),
    .angle_i      (angle_q),
    .total_i      (new_total),
    .prev_angle_o (prev_angle),
    .prev_total_o (prev_total)
  );

  mmeu_step_calc #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_step (
    .old_angle_i (prev_angle),
    .new_angle_i (angle_q),
    .step_o      (step)
  );

  // Accumulate the step and build the result fields; bad numbers give zeros.
  assign step_ext  = {{(TotW - ANGLE_BITS - 1){step[ANGLE_BITS]}}, step};
  assign new_total = prev_total + step_ext;

  always_comb begin
    if (num_ok_d) begin
      slot_d  = number_m1[mmeu_pkg::SlotOutW-1:0];
      total_d = new_total;
      step_d  = step_ext[mmeu_pkg::StepW-1:0];
    end else begin
      slot_d  = '0;
      total_d = '0;
      step_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      slot_q      <= slot_d;
      num_ok_q    <= num_ok_d;
      total_q     <= total_d;
      step_q      <= step_d;
      speed_out_q <= speed_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_slot_o   = slot_q;
  assign number_valid_o = num_ok_q;
  assign angle_total_o  = total_q;
  assign angle_step_o   = step_q;
  assign speed_out_o    = speed_out_q;

  // Checks on the stage control and the result beat.
  `MMEU_ASSERT_NOW(a_bad_number_zeroed, out_valid_q && !num_ok_q, (slot_q == '0) && (total_q == '0) && (step_q == '0), "rejected frame carries nonzero result fields")
  `MMEU_ASSERT_NOW(a_stall_reason, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stage stalled without a blocked result")
  `MMEU_ASSERT_NEXT(a_fire_fills_output, fire, out_valid_q && (num_ok_q == $past(num_ok_d)), "processed frame did not reach the result register")

endmodule
